// ----- rtl/sofl_pkg.sv -----
// Shared types, widths and codes of the slab object free list.
`timescale 1ns / 1ps
package sofl_pkg;

  // Largest number of objects that one slab can hold.
  localparam int MaxObjects = 1024;
  localparam int IdxW       = $clog2(MaxObjects);
  localparam int CntW       = IdxW + 1;

  // Field widths of the item and result ports.
  localparam int OpW     = 2;
  localparam int OffW    = 22;
  localparam int StatusW = 3;
  localparam int SizeW   = 16;
  localparam int SlabW   = 23;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 23;

  // Link memory entry: allocated flag on top of the next index.
  localparam int LinkW = IdxW + 1;

  // Largest usable slab area; bigger register values are clamped to it.
  localparam logic [SlabW-1:0] AreaLimit = SlabW'(4194304);

  // Object size register reset value and slab bytes register reset value.
  localparam logic [SizeW-1:0] SizeReset = SizeW'(64);
  localparam logic [SlabW-1:0] SlabReset = SlabW'(4096);

  // Shared divider widths.
  localparam int DivNW   = SlabW;
  localparam int DivDW   = SizeW + 1;
  localparam int DivCntW = $clog2(DivNW + 1);

  // Product of object size and an object count or index.
  localparam int ProdW = SizeW + CntW;

  // Operation codes.
  localparam logic [OpW-1:0] OpFormat = 2'd0;
  localparam logic [OpW-1:0] OpAlloc  = 2'd1;
  localparam logic [OpW-1:0] OpFree   = 2'd2;

  // Status codes.
  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StEmpty    = 3'd1;
  localparam logic [StatusW-1:0] StRange    = 3'd2;
  localparam logic [StatusW-1:0] StAlign    = 3'd3;
  localparam logic [StatusW-1:0] StNotAlloc = 3'd4;
  localparam logic [StatusW-1:0] StNoRoom   = 3'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgObjectSize = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSlabBytes  = 2'd1;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivNW-1:0] quotient;
    logic [DivDW-1:0] remainder;
  } div_rsp_t;

endpackage

// ----- rtl/sofl_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module sofl_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sofl_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module sofl_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sofl_pkg::div_req_t  req_i,
  output sofl_pkg::div_rsp_t  rsp_o
);
  import sofl_pkg::*;

  logic               active_q, active_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivNW-1:0]   quo_q, quo_d;
  logic [DivDW-1:0]   rem_q, rem_d;
  logic [DivDW-1:0]   divisor_q, divisor_d;
  logic [DivDW:0]     partial;
  logic [DivDW:0]     diff;
  logic               fits;

  // One step: bring down the next dividend bit and try a subtraction.
  assign partial = {rem_q, quo_q[DivNW-1]};
  assign diff    = partial - {1'b0, divisor_q};
  assign fits    = partial >= {1'b0, divisor_q};

  always_comb begin
    active_d  = active_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (req_i.start) begin
      active_d  = 1'b1;
      cnt_d     = DivCntW'(DivNW);
      quo_d     = req_i.dividend;
      rem_d     = '0;
      divisor_d = req_i.divisor;
    end else if (active_q) begin
      rem_d = fits ? diff[DivDW-1:0] : partial[DivDW-1:0];
      quo_d = {quo_q[DivNW-2:0], fits};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ----- rtl/slab_object_free_list.sv -----
// Top level of the slab object free list: sequencer, state registers and link memory.
`timescale 1ns / 1ps
// The block keeps the free objects of one slab in a FIFO list linked by
// object index. An item is taken when start is high and busy is low; its one
// result appears on the result ports for exactly one cycle with done_o high,
// and the receiver cannot stall it. Allocate does a link memory read, then
// the head update. Free does the range product, a 23-step pass through the
// shared bit-serial divider that turns the byte offset into an index, and a
// read-modify-write of the link memory. Format has the divider compute the
// new object count, then fills the link memory one entry per cycle.
// The link memory needs no clearing pass after reset, since every entry that
// a later item can reach is written by the format that makes it reachable.
// Configuration writes are always taken and must only be made while the
// block is idle.
module slab_object_free_list (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [sofl_pkg::OpW-1:0]      operation_i,
  input  logic [sofl_pkg::OffW-1:0]     free_offset_i,
  output logic                          done_o,
  output logic [sofl_pkg::StatusW-1:0]  status_o,
  output logic [sofl_pkg::OffW-1:0]     object_offset_o,
  output logic [sofl_pkg::CntW-1:0]     free_count_o,
  output logic [sofl_pkg::CntW-1:0]     total_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sofl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sofl_pkg::CfgDatW-1:0]  cfg_data_i
);
  import sofl_pkg::*;

  // Sequencer states.
  localparam logic [3:0] SIdle     = 4'd0;
  localparam logic [3:0] SDivFmt   = 4'd1;
  localparam logic [3:0] SFill     = 4'd2;
  localparam logic [3:0] SAllocRd  = 4'd3;
  localparam logic [3:0] SAllocWr  = 4'd4;
  localparam logic [3:0] SFreeMul  = 4'd5;
  localparam logic [3:0] SFreeChk  = 4'd6;
  localparam logic [3:0] SDivFree  = 4'd7;
  localparam logic [3:0] SFreeRd   = 4'd8;
  localparam logic [3:0] SFreeTst  = 4'd9;
  localparam logic [3:0] SFreeLnk  = 4'd10;

  logic [3:0]         state_q, state_d;
  logic [SizeW-1:0]   size_q, size_d;
  logic [SlabW-1:0]   slab_q, slab_d;
  logic [IdxW-1:0]    head_q, head_d;
  logic [IdxW-1:0]    tail_q, tail_d;
  logic [CntW-1:0]    free_q, free_d;
  logic [CntW-1:0]    all_q, all_d;
  logic               done_q, done_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [OffW-1:0]    offset_q, offset_d;

  // Payload registers of the sequencer.
  logic [OffW-1:0]    foff_q, foff_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [IdxW-1:0]    fill_q, fill_d;
  logic [ProdW-1:0]   prod_q;
  logic [CntW-1:0]    mul_b;

  // Link memory port.
  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  logic [LinkW-1:0]   ram_wdata;
  logic [IdxW-1:0]    ram_raddr;
  logic [LinkW-1:0]   ram_rdata;

  // Shared divider.
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [SlabW-1:0]   slab_clamped;
  logic [CntW-1:0]    fmt_count;
  logic [CntW-1:0]    fill_next;
  logic [IdxW-1:0]    free_idx;

  assign busy        = (state_q != SIdle);
  assign cfg_ready_o = 1'b1;

  assign slab_clamped = (slab_q > AreaLimit) ? AreaLimit : slab_q;

  // Object count from the divider, saturated at the list capacity.
  assign fmt_count = (div_rsp.quotient > DivNW'(MaxObjects)) ? CntW'(MaxObjects)
                                                            : div_rsp.quotient[CntW-1:0];
  assign fill_next = {1'b0, fill_q} + CntW'(1);
  assign free_idx  = div_rsp.quotient[IdxW-1:0];

  // The single multiplier forms either the allocated offset or the object area.
  assign mul_b = (state_q == SAllocRd) ? {1'b0, head_q} : all_q;

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(size_q) * ProdW'(mul_b);
  end

  always_comb begin
    state_d   = state_q;
    size_d    = size_q;
    slab_d    = slab_q;
    head_d    = head_q;
    tail_d    = tail_q;
    free_d    = free_q;
    all_d     = all_q;
    done_d    = 1'b0;
    status_d  = status_q;
    offset_d  = offset_q;
    foff_d    = foff_q;
    count_d   = count_q;
    fill_d    = fill_q;
    ram_we    = 1'b0;
    ram_waddr = fill_q;
    ram_wdata = {1'b0, fill_q};
    ram_raddr = head_q;
    div_req.start    = 1'b0;
    div_req.dividend = slab_clamped;
    div_req.divisor  = DivDW'(size_q) + DivDW'(4);

    // Configuration writes; indexes beyond the list are dropped.
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgObjectSize: size_d = cfg_data_i[SizeW-1:0];
        CfgSlabBytes:  slab_d = cfg_data_i[SlabW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      SIdle: begin
        if (start) begin
          foff_d   = free_offset_i;
          offset_d = '0;
          case (operation_i)
            OpFormat: begin
              // Object count is slab bytes over link word plus object size.
              div_req.start = 1'b1;
              state_d       = SDivFmt;
            end
            OpAlloc: begin
              if (free_q == '0) begin
                status_d = StEmpty;
                done_d   = 1'b1;
              end else begin
                state_d = SAllocRd;
              end
            end
            OpFree: begin
              state_d = SFreeMul;
            end
            default: begin
              status_d = StRange;
              done_d   = 1'b1;
            end
          endcase
        end
      end

      SDivFmt: begin
        if (div_rsp.done) begin
          if (fmt_count == '0) begin
            status_d = StNoRoom;
            done_d   = 1'b1;
            state_d  = SIdle;
          end else begin
            count_d = fmt_count;
            fill_d  = '0;
            state_d = SFill;
          end
        end
      end

      SFill: begin
        // Link each entry to the next; the last one points at itself.
        ram_we    = 1'b1;
        ram_waddr = fill_q;
        if (fill_next == count_q) begin
          ram_wdata = {1'b0, fill_q};
          head_d    = '0;
          tail_d    = fill_q;
          free_d    = count_q;
          all_d     = count_q;
          status_d  = StOk;
          done_d    = 1'b1;
          state_d   = SIdle;
        end else begin
          ram_wdata = {1'b0, fill_next[IdxW-1:0]};
          fill_d    = fill_next[IdxW-1:0];
        end
      end

      SAllocRd: begin
        ram_raddr = head_q;
        state_d   = SAllocWr;
      end

      SAllocWr: begin
        // Mark the head taken, keep its link, and advance the head.
        ram_we    = 1'b1;
        ram_waddr = head_q;
        ram_wdata = {1'b1, ram_rdata[IdxW-1:0]};
        head_d    = ram_rdata[IdxW-1:0];
        free_d    = free_q - CntW'(1);
        offset_d  = prod_q[OffW-1:0];
        status_d  = StOk;
        done_d    = 1'b1;
        state_d   = SIdle;
      end

      SFreeMul: begin
        state_d = SFreeChk;
      end

      SFreeChk: begin
        if ((ProdW'(foff_q) >= prod_q) || (size_q == '0)) begin
          status_d = StRange;
          done_d   = 1'b1;
          state_d  = SIdle;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DivNW'(foff_q);
          div_req.divisor  = DivDW'(size_q);
          state_d          = SDivFree;
        end
      end

      SDivFree: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder != '0) begin
            status_d = StAlign;
            done_d   = 1'b1;
            state_d  = SIdle;
          end else begin
            state_d = SFreeRd;
          end
        end
      end

      SFreeRd: begin
        ram_raddr = free_idx;
        state_d   = SFreeTst;
      end

      SFreeTst: begin
        if (!ram_rdata[IdxW]) begin
          status_d = StNotAlloc;
          done_d   = 1'b1;
          state_d  = SIdle;
        end else begin
          // The freed object becomes the new tail and points at itself.
          ram_we    = 1'b1;
          ram_waddr = free_idx;
          ram_wdata = {1'b0, free_idx};
          if (free_q == '0) begin
            head_d   = free_idx;
            tail_d   = free_idx;
            free_d   = free_q + CntW'(1);
            status_d = StOk;
            done_d   = 1'b1;
            state_d  = SIdle;
          end else begin
            state_d = SFreeLnk;
          end
        end
      end

      SFreeLnk: begin
        // Hook the freed object behind the old tail.
        ram_we    = 1'b1;
        ram_waddr = tail_q;
        ram_wdata = {1'b0, free_idx};
        tail_d    = free_idx;
        free_d    = free_q + CntW'(1);
        status_d  = StOk;
        done_d    = 1'b1;
        state_d   = SIdle;
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      size_q   <= SizeReset;
      slab_q   <= SlabReset;
      head_q   <= '0;
      tail_q   <= '0;
      free_q   <= '0;
      all_q    <= '0;
      done_q   <= 1'b0;
      status_q <= StOk;
      offset_q <= '0;
    end else begin
      state_q  <= state_d;
      size_q   <= size_d;
      slab_q   <= slab_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      free_q   <= free_d;
      all_q    <= all_d;
      done_q   <= done_d;
      status_q <= status_d;
      offset_q <= offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    foff_q  <= foff_d;
    count_q <= count_d;
    fill_q  <= fill_d;
  end

  sofl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sofl_ram #(
    .WIDTH (LinkW),
    .DEPTH (MaxObjects)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The counts are state registers that update on the edge that raises done_o.
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign object_offset_o = offset_q;
  assign free_count_o    = free_q;
  assign total_count_o   = all_q;

endmodule
